// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the skinning block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbvs_pkg
// Types, constants and helpers shared by the four-bone skinning block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbvs_pkg;

	localparam int IDX_W     = 6;
	localparam int NUM_LANES = 4;
	localparam int ELEMS     = 16;
	localparam int SCALE_W   = 23;
	localparam int WGT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = 32;
	// Divider: operand setup, one quotient bit per stage, sign and saturation.
	localparam int DIV_LAT   = DIV_STEPS + 2;
	// Lane: read, multiply, sum, magnitude, divider, scale multiply, saturate.
	localparam int LANE_LAT  = DIV_LAT + 6;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 23'd65536;
	localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_SKIN = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X = 2'd0,
		REG_SCALE_Y = 2'd1,
		REG_SCALE_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [5:0]         load_bone;
		logic [3:0]         load_element;
		logic signed [31:0] load_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [23:0]        bone_indices;
		logic [15:0]        weight_one;
		logic [15:0]        weight_two;
		logic [15:0]        weight_three;
		logic [15:0]        weight_four;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_zero;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] bone;
		logic [3:0]       elem;
		logic [31:0]      data;
	} mem_wr_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(SAT_MAX)) begin
			return SAT_MAX;
		end
		if (v < 64'(SAT_MIN)) begin
			return SAT_MIN;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/fbvs_div.sv =====
// ----------------------------------------------------------------------------
// fbvs_div
// Pipelined restoring divider: num * 2^FRAC_BITS / den, truncated toward
// zero and saturated to 32-bit signed, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fbvs_div #(
	parameter int HW        = 50,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               adv,
	input  logic [HW-1:0]      num,
	input  logic [HW-1:0]      den,
	input  logic               neg,
	output logic signed [31:0] quot
);

	localparam int SH = 32 - FRAC_BITS;
	localparam int CW = HW + SH;
	localparam int N  = fbvs_pkg::DIV_STEPS;

	logic [HW-1:0] r_s   [N+1];
	logic [31:0]   qn_s  [N+1];
	logic [HW-1:0] den_s [N+1];
	logic          neg_s [N+1];
	logic          ovf_s [N+1];

	// The quotient bits shift in at the bottom of qn while the low dividend
	// bits shift out at the top.
	function automatic logic [HW+31:0] div_step(input logic [HW-1:0] r,
		input logic [31:0] qn, input logic [HW-1:0] d);
		logic [HW:0] trial;
		logic        ge;
		trial = {r, qn[31]};
		ge    = trial >= {1'b0, d};
		return {(ge ? HW'(trial - {1'b0, d}) : HW'(trial)), qn[30:0], ge};
	endfunction

	function automatic logic signed [31:0] fix_sign(input logic [31:0] mag,
		input logic n, input logic ovf);
		if (ovf) begin
			return n ? fbvs_pkg::SAT_MIN : fbvs_pkg::SAT_MAX;
		end
		if (n) begin
			return (mag > 32'h8000_0000) ? fbvs_pkg::SAT_MIN : $signed(-mag);
		end
		return mag[31] ? fbvs_pkg::SAT_MAX : $signed(mag);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			// A quotient of 2^32 or more saturates whatever its sign.
			r_s[0]   <= num >> SH;
			qn_s[0]  <= 32'(num << FRAC_BITS);
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= CW'(num) >= {den, {SH{1'b0}}};
			for (int k = 0; k < N; k++) begin
				{r_s[k+1], qn_s[k+1]} <= div_step(r_s[k], qn_s[k], den_s[k]);
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
			quot <= fix_sign(qn_s[N], neg_s[N], ovf_s[N]);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fbvs_lane.sv =====
// ----------------------------------------------------------------------------
// fbvs_lane
// One bone slot: a private copy of the matrix store, the point transform,
// the perspective divide per axis and the per-axis scale.
// ----------------------------------------------------------------------------
`default_nettype none

module fbvs_lane #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              adv,
	input  fbvs_pkg::mem_wr_t                 wr,
	input  logic [fbvs_pkg::IDX_W-1:0]        rd_bone,
	input  logic signed [31:0]                pos   [3],
	input  logic [fbvs_pkg::SCALE_W-1:0]      scale [3],
	output logic signed [31:0]                coord [3],
	output logic                              w_zero
);

	localparam int AW     = $clog2(MAX_BONES);
	localparam int HW     = 66 - FRAC_BITS;
	localparam int WZ_DLY = fbvs_pkg::LANE_LAT - 4;

	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic               wr_hit;
	logic               rd_oob;
	logic signed [31:0] m_rd [fbvs_pkg::ELEMS];

	logic               oob_s1;
	logic signed [31:0] p_s1    [3];
	logic signed [63:0] prod_s2 [3][4];
	logic signed [31:0] t_s2    [4];
	logic signed [HW-1:0] h_s3  [4];
	logic [HW-1:0]      num_s4  [3];
	logic [HW-1:0]      den_s4;
	logic               neg_s4  [3];
	logic               wz_s4;
	logic signed [31:0] q_s38   [3];
	logic signed [55:0] sp_s39  [3];
	logic signed [31:0] c_s40   [3];
	logic [WZ_DLY-1:0]  wz_q;

	assign wr_addr = AW'(wr.bone);
	assign rd_addr = AW'(rd_bone);
	assign wr_hit  = wr.en && (32'(wr.bone) < 32'(MAX_BONES));
	assign rd_oob  = !(32'(rd_bone) < 32'(MAX_BONES));

	// One memory per matrix element, so a whole matrix reads at once.
	for (genvar e = 0; e < fbvs_pkg::ELEMS; e++) begin : g_elem
		logic [31:0] mem [MAX_BONES];
		logic [31:0] rd_s1;

		always_ff @(posedge clk) begin
			if (wr_hit && (wr.elem == 4'(e))) begin
				mem[wr_addr] <= wr.data;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_s1 <= mem[rd_addr];
			end
		end

		assign m_rd[e] = rd_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oob_s1 <= rd_oob;
			for (int ax = 0; ax < 3; ax++) begin
				p_s1[ax] <= pos[ax];
			end
		end
	end

	// A bone index past the store reads as an all-zero matrix.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int col = 0; col < 4; col++) begin
				t_s2[col] <= oob_s1 ? '0 : m_rd[12+col];
				for (int row = 0; row < 3; row++) begin
					prod_s2[row][col] <= oob_s1 ? 64'sd0
						: p_s1[row] * m_rd[row*4+col];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int col = 0; col < 4; col++) begin
				h_s3[col] <= HW'(t_s2[col])
					+ HW'(prod_s2[0][col] >>> FRAC_BITS)
					+ HW'(prod_s2[1][col] >>> FRAC_BITS)
					+ HW'(prod_s2[2][col] >>> FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_s4  <= (h_s3[3] == '0);
			den_s4 <= h_s3[3][HW-1] ? HW'(-h_s3[3]) : HW'(h_s3[3]);
			for (int ax = 0; ax < 3; ax++) begin
				num_s4[ax] <= h_s3[ax][HW-1] ? HW'(-h_s3[ax]) : HW'(h_s3[ax]);
				neg_s4[ax] <= h_s3[ax][HW-1] ^ h_s3[3][HW-1];
			end
		end
	end

	for (genvar ax = 0; ax < 3; ax++) begin : g_div
		fbvs_div #(
			.HW        (HW),
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk  (clk),
			.adv  (adv),
			.num  (num_s4[ax]),
			.den  (den_s4),
			.neg  (neg_s4[ax]),
			.quot (q_s38[ax])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_q <= {wz_q[WZ_DLY-2:0], wz_s4};
			for (int ax = 0; ax < 3; ax++) begin
				sp_s39[ax] <= q_s38[ax] * $signed({1'b0, scale[ax]});
				c_s40[ax]  <= fbvs_pkg::sat32(64'(sp_s39[ax] >>> FRAC_BITS));
			end
		end
	end

	assign coord  = c_s40;
	assign w_zero = wz_q[WZ_DLY-1];

endmodule

`default_nettype wire

// ===== hdl/four_bone_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// four_bone_vertex_skinning: four-bone linear blend skinning, Q16.16
// Accept to result valid: lanes, weight multiply, sum, output, plus stalls.
// Throughput: one item per cycle unless stalled; the 32-stage divider per axis sets depth.
// Load items write the matrix store at accept and give no result.
// Reset clears the pipeline valid bits and sets all scales to 1.0;
// the matrix store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module four_bone_vertex_skinning #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fbvs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbvs_pkg::SCALE_W-1:0]        cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  fbvs_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output fbvs_pkg::result_t                   result
);

	localparam int LANES   = fbvs_pkg::NUM_LANES;
	localparam int LAT     = fbvs_pkg::LANE_LAT;
	localparam int TOP_LAT = LAT + 3;

	logic                          adv;
	logic                          accept;
	fbvs_pkg::mem_wr_t             wr;
	logic [fbvs_pkg::SCALE_W-1:0]  scale_q [3];
	logic signed [31:0]            pos [3];
	logic signed [31:0]            coord_l [LANES][3];
	logic                          wz_l [LANES];
	logic [TOP_LAT-1:0]            vld_q;
	logic [fbvs_pkg::WGT_W-1:0]    wgt_q [LAT][LANES];
	logic                          wz_any;

	logic signed [48:0]            wp_s41  [LANES][3];
	logic                          wz_s41;
	logic signed [50:0]            acc_s42 [3];
	logic                          wz_s42;
	fbvs_pkg::result_t             result_s43;

	// The whole pipeline holds only while a finished result is refused.
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;

	assign wr.en   = accept && (item.cmd == fbvs_pkg::CMD_LOAD);
	assign wr.bone = item.load_bone;
	assign wr.elem = item.load_element;
	assign wr.data = item.load_value;

	assign pos[0] = item.pos_x;
	assign pos[1] = item.pos_y;
	assign pos[2] = item.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ax = 0; ax < 3; ax++) begin
				scale_q[ax] <= fbvs_pkg::SCALE_ONE;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				fbvs_pkg::REG_SCALE_X: scale_q[0] <= cfg_data;
				fbvs_pkg::REG_SCALE_Y: scale_q[1] <= cfg_data;
				fbvs_pkg::REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		fbvs_lane #(
			.MAX_BONES (MAX_BONES),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.wr      (wr),
			.rd_bone (item.bone_indices[l*fbvs_pkg::IDX_W +: fbvs_pkg::IDX_W]),
			.pos     (pos),
			.scale   (scale_q),
			.coord   (coord_l[l]),
			.w_zero  (wz_l[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOP_LAT-2:0], accept && (item.cmd == fbvs_pkg::CMD_SKIN)};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wgt_q[0] <= '{item.weight_one, item.weight_two,
				item.weight_three, item.weight_four};
			for (int i = 1; i < LAT; i++) begin
				wgt_q[i] <= wgt_q[i-1];
			end
		end
	end

	// Bones three and four only count toward the zero-w flag when weighted.
	assign wz_any = wz_l[0] || wz_l[1]
		|| ((wgt_q[LAT-1][2] != '0) && wz_l[2])
		|| ((wgt_q[LAT-1][3] != '0) && wz_l[3]);

	// A skipped bone may point at a matrix that was never loaded, so its
	// coordinate is not trusted and a zero weight forces a zero product.
	always_ff @(posedge clk) begin
		if (adv) begin
			wz_s41 <= wz_any;
			for (int l = 0; l < LANES; l++) begin
				for (int ax = 0; ax < 3; ax++) begin
					wp_s41[l][ax] <= (wgt_q[LAT-1][l] == '0) ? 49'sd0
						: coord_l[l][ax] * $signed({1'b0, wgt_q[LAT-1][l]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_s42 <= wz_s41;
			for (int ax = 0; ax < 3; ax++) begin
				acc_s42[ax] <= 51'(wp_s41[0][ax]) + 51'(wp_s41[1][ax])
					+ 51'(wp_s41[2][ax]) + 51'(wp_s41[3][ax]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s43.w_zero <= wz_s42;
			result_s43.out_x  <= wz_s42 ? '0 : fbvs_pkg::sat32(64'(acc_s42[0] >>> 15));
			result_s43.out_y  <= wz_s42 ? '0 : fbvs_pkg::sat32(64'(acc_s42[1] >>> 15));
			result_s43.out_z  <= wz_s42 ? '0 : fbvs_pkg::sat32(64'(acc_s42[2] >>> 15));
		end
	end

	assign result       = result_s43;
	assign result_valid = vld_q[TOP_LAT-1];

	`ASSERT_IMPL(a_wz_gives_zero, clk, arst_n, result_valid && result.w_zero,
		result.out_x == '0 && result.out_y == '0 && result.out_z == '0,
		"zero-w result carries a nonzero coordinate")
	`ASSERT_NEXT(a_load_no_result, clk, arst_n,
		item_valid && !item_stall && item.cmd == fbvs_pkg::CMD_LOAD, !vld_q[0],
		"load item entered the result pipeline")
	`ASSERT_NEXT(a_skin_enters, clk, arst_n,
		item_valid && !item_stall && item.cmd == fbvs_pkg::CMD_SKIN, vld_q[0],
		"accepted vertex item was lost at pipeline entry")
	`ASSERT_NEXT(a_scale_x_write, clk, arst_n,
		cfg_we && cfg_index == fbvs_pkg::REG_SCALE_X, scale_q[0] == $past(cfg_data),
		"scale_x register did not take the written value")

endmodule

`default_nettype wire

// ===== tb/sv/tb_four_bone_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// tb_four_bone_vertex_skinning
// Loads bone matrices, streams vertex items under random gaps and stalls,
// and checks every skinned position against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_bone_vertex_skinning;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [fbvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int NBONES = 64;
	localparam int TAIL_CYCLES = fbvs_pkg::LANE_LAT + 40;
	localparam int ITEM_W = $bits(fbvs_pkg::item_t);

	// Bone fill styles for generated matrices.
	localparam int BONE_RIGID = 0;
	localparam int BONE_WILD = 1;
	localparam int BONE_FLAT_W = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [fbvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fbvs_pkg::SCALE_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	fbvs_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	fbvs_pkg::result_t result;

	always #5 clk = ~clk;

	four_bone_vertex_skinning u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	class skin_checker;
		int bone_words[NBONES*16];
		logic [fbvs_pkg::SCALE_W-1:0] scale[3];
		fbvs_pkg::result_t expected_pos[$];
		int errors;

		function new();
			scale = '{fbvs_pkg::SCALE_ONE, fbvs_pkg::SCALE_ONE, fbvs_pkg::SCALE_ONE};
			errors = 0;
		endfunction

		task report(string what);
			$display("mismatch @%0t: %s", $realtime, what);
			errors++;
		endtask

		function automatic longint clamp32(longint v);
			if (v > 64'sh7FFF_FFFF) begin
				return 64'sh7FFF_FFFF;
			end
			if (v < -64'sh8000_0000) begin
				return -64'sh8000_0000;
			end
			return v;
		endfunction

		// Fixed-point n / d with 16 fraction bits, truncated toward zero.
		function automatic longint divide_q(longint n, longint d);
			bit neg;
			longint unsigned a, b, q0, r, fr, mag;
			neg = (n < 0) != (d < 0);
			a = n < 0 ? -n : n;
			b = d < 0 ? -d : d;
			q0 = a / b;
			r = a % b;
			if (q0 >= 64'd65536) begin
				mag = 64'h1_0000_0000;
			end else begin
				fr = 0;
				for (int i = 0; i < 16; i++) begin
					r = r << 1;
					fr = fr << 1;
					if (r >= b) begin
						r -= b;
						fr |= 1;
					end
				end
				mag = (q0 << 16) | fr;
			end
			return clamp32(neg ? -longint'(mag) : longint'(mag));
		endfunction

		// One bone: transform, divide by w, scale. Returns 0 when w is zero.
		function automatic bit bone_point(int bone, longint p[3], output longint c[3]);
			longint h[4];
			longint q;
			for (int col = 0; col < 4; col++) begin
				h[col] = longint'(bone_words[bone*16 + 12 + col]);
				for (int row = 0; row < 3; row++) begin
					h[col] += (p[row] * longint'(bone_words[bone*16 + row*4 + col])) >>> 16;
				end
			end
			c = '{0, 0, 0};
			if (h[3] == 0) begin
				return 1'b0;
			end
			for (int col = 0; col < 3; col++) begin
				q = divide_q(h[col], h[3]);
				c[col] = clamp32((q * longint'({41'd0, scale[col]})) >>> 16);
			end
			return 1'b1;
		endfunction

		function automatic fbvs_pkg::result_t skin_vertex(fbvs_pkg::item_t it);
			longint p[3], c[3], acc[3];
			logic [15:0] w[4];
			bit wz;
			fbvs_pkg::result_t r;
			p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
			acc = '{0, 0, 0};
			w = '{it.weight_one, it.weight_two, it.weight_three, it.weight_four};
			wz = 1'b0;
			for (int k = 0; k < 4; k++) begin
				if (k >= 2 && w[k] == 0) begin
					continue;
				end
				if (!bone_point(int'(it.bone_indices[6*k +: 6]), p, c)) begin
					wz = 1'b1;
					continue;
				end
				for (int j = 0; j < 3; j++) begin
					acc[j] += c[j] * longint'({48'd0, w[k]});
				end
			end
			r.out_x = wz ? 32'sd0 : 32'(clamp32(acc[0] >>> 15));
			r.out_y = wz ? 32'sd0 : 32'(clamp32(acc[1] >>> 15));
			r.out_z = wz ? 32'sd0 : 32'(clamp32(acc[2] >>> 15));
			r.w_zero = wz;
			return r;
		endfunction

		function void note_item(fbvs_pkg::item_t it);
			if (it.cmd == fbvs_pkg::CMD_LOAD) begin
				bone_words[int'(it.load_bone)*16 + int'(it.load_element)] = it.load_value;
			end else begin
				expected_pos.insert(expected_pos.size(), skin_vertex(it));
			end
		endfunction

		task check_result(fbvs_pkg::result_t got);
			fbvs_pkg::result_t exp;
			if (expected_pos.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				exp = expected_pos.pop_front();
				if (got !== exp) begin
					report($sformatf("got x=%h y=%h z=%h wz=%b exp x=%h y=%h z=%h wz=%b",
						got.out_x, got.out_y, got.out_z, got.w_zero,
						exp.out_x, exp.out_y, exp.out_z, exp.w_zero));
				end
			end
		endtask
	endclass

	skin_checker sb = new();

	// Stimulus-side bookkeeping of which store entries hold data.
	bit loaded[NBONES][16];
	int ready_bones[$];
	bit no_idle = 1'b0;
	int hold_cycles = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sb.note_item(item);
			end
			if (result_valid && !result_stall) begin
				sb.check_result(result);
				stall_left = no_idle ? 0 : $urandom_range(0, 18);
			end
		end
	end

	// Receiver: per-result random stall, plus long hold-offs on request.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Called at a falling edge; returns at the falling edge after accept.
	task send(fbvs_pkg::item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Random filler for the fields that an item's command does not use.
	function automatic fbvs_pkg::item_t random_item();
		logic [255:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		return fbvs_pkg::item_t'(raw[ITEM_W-1:0]);
	endfunction

	function automatic logic [31:0] make_elem(int style, int e);
		int r;
		if (style == BONE_WILD) begin
			r = $urandom_range(0, 3);
			return r == 0 ? 32'h7FFF_FFFF : r == 1 ? 32'h8000_0000 : $urandom;
		end
		if (style == BONE_FLAT_W && e % 4 == 3) begin
			return 32'd0;
		end
		if (e == 15) begin
			return 32'd65536 + 32'($signed($urandom_range(0, 2048)) - 1024);
		end
		if (e % 4 == 3) begin
			return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($signed($urandom_range(0, 512)) - 256);
		end
		if (e >= 12) begin
			return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		end
		if (e / 4 == e % 4) begin
			return 32'd65536 + 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
		end
		return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
	endfunction

	task load_elem(int bone, int e, logic [31:0] v);
		fbvs_pkg::item_t it;
		it = random_item();
		it.cmd = fbvs_pkg::CMD_LOAD;
		it.load_bone = 6'(bone);
		it.load_element = 4'(e);
		it.load_value = v;
		send(it);
		if (!loaded[bone][e]) begin
			loaded[bone][e] = 1'b1;
			if (loaded[bone].sum(b) with (int'(b)) == 16) begin
				ready_bones.insert(ready_bones.size(), bone);
			end
		end
	endtask

	task load_bone(int bone, int style);
		for (int e = 0; e < 16; e++) begin
			load_elem(bone, e, make_elem(style, e));
		end
	endtask

	function automatic int pick_bone();
		return ready_bones[$urandom_range(0, ready_bones.size() - 1)];
	endfunction

	function automatic logic [31:0] make_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		if (r < 4) begin
			return $urandom;
		end
		return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
	endfunction

	task send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			int b0, int b1, int b2, int b3,
			logic [15:0] w0, logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
		fbvs_pkg::item_t it;
		it = random_item();
		it.cmd = fbvs_pkg::CMD_SKIN;
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		it.bone_indices = {6'(b3), 6'(b2), 6'(b1), 6'(b0)};
		it.weight_one = w0;
		it.weight_two = w1;
		it.weight_three = w2;
		it.weight_four = w3;
		send(it);
	endtask

	task random_vertex();
		int w[4], left, b2, b3;
		if ($urandom_range(0, 2) != 0) begin
			// Weights that sum to one.
			left = 32768;
			for (int k = 0; k < 3; k++) begin
				w[k] = $urandom_range(0, left);
				left -= w[k];
			end
			w[3] = left;
		end else begin
			for (int k = 0; k < 4; k++) begin
				w[k] = $urandom_range(0, 32768);
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			w[2] = 0;
		end
		if ($urandom_range(0, 2) == 0) begin
			w[3] = 0;
		end
		// A skipped bone's matrix is read but its product forced to zero, so its index may be anything.
		b2 = (w[2] == 0) ? $urandom_range(0, 63) : pick_bone();
		b3 = (w[3] == 0) ? $urandom_range(0, 63) : pick_bone();
		send_vertex(make_pos(), make_pos(), make_pos(), pick_bone(), pick_bone(), b2, b3,
			16'(w[0]), 16'(w[1]), 16'(w[2]), 16'(w[3]));
	endtask

	task random_phase(int count);
		int r, bone;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 19);
			if (r == 0) begin
				bone = $urandom_range(0, 63);
				load_bone(bone, $urandom_range(0, 5) == 0 ? BONE_FLAT_W
					: $urandom_range(0, 3) == 0 ? BONE_WILD : BONE_RIGID);
				n += 15;
			end else if (r < 4) begin
				if ($urandom_range(0, 3) == 0) begin
					load_elem($urandom_range(0, 63), $urandom_range(0, 15), $urandom);
				end else begin
					bone = pick_bone();
					r = $urandom_range(0, 15);
					load_elem(bone, r, make_elem(BONE_RIGID, r));
				end
			end else begin
				random_vertex();
			end
		end
		no_idle = 1'b0;
	endtask

	task write_reg(logic [fbvs_pkg::CFG_IDX_W-1:0] idx, logic [fbvs_pkg::SCALE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx <= fbvs_pkg::REG_SCALE_Z) begin
			sb.scale[idx] = v;
		end
	endtask

	// Wait until the pipeline has drained; called and returns at a falling edge.
	task drain();
		item_valid <= 1'b0;
		while (sb.expected_pos.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task set_scales(logic [fbvs_pkg::SCALE_W-1:0] sx, logic [fbvs_pkg::SCALE_W-1:0] sy,
			logic [fbvs_pkg::SCALE_W-1:0] sz);
		drain();
		write_reg(fbvs_pkg::REG_SCALE_X, sx);
		write_reg(fbvs_pkg::REG_SCALE_Y, sy);
		write_reg(fbvs_pkg::REG_SCALE_Z, sz);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bones 0 and 63 toggle every index bit; bone 5 has w of zero.
		load_bone(0, BONE_RIGID);
		load_bone(63, BONE_RIGID);
		load_bone(5, BONE_FLAT_W);
		load_bone(42, BONE_WILD);
		for (int i = 0; i < 4; i++) begin
			load_bone($urandom_range(6, 41), BONE_RIGID);
		end

		// Directed vertices.
		send_vertex(0, 0, 0, 0, 63, 0, 63, 16'd32768, 16'd0, 16'd0, 16'd0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 63, 0,
			16'd32768, 16'd32768, 16'd32768, 16'd32768);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 63, 63, 0, 63,
			16'd32768, 16'd32768, 16'd32768, 16'd32768);
		send_vertex(32'hFFFF_FFFF, 32'd65536, 32'hFFFF_0000, 0, 63, 1, 2,
			16'd16384, 16'd16384, 16'd0, 16'd0);
		send_vertex(32'd65536, 32'd131072, 32'd196608, 5, 0, 0, 0,
			16'd32768, 16'd0, 16'd0, 16'd0);
		send_vertex(32'd65536, 32'd65536, 32'd65536, 0, 0, 5, 0,
			16'd16384, 16'd16384, 16'd0, 16'd0);
		send_vertex(32'd65536, 32'd65536, 32'd65536, 0, 63, 0, 5, 16'd8192, 16'd8192,
			16'd8192, 16'd8192);
		send_vertex(32'd65536, 32'd65536, 32'd65536, 0, 0, 0, 5, 16'd8192, 16'd8192,
			16'd16384, 16'd0);
		send_vertex(32'h0123_4567, 32'hFEDC_BA98, 32'h0000_8000, 42, 42, 42, 42,
			16'd32768, 16'd0, 16'd1, 16'd1);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, 42, 0, 0, 0,
			16'd0, 16'd0, 16'd0, 16'd0);

		random_phase(180);

		set_scales(23'd4194304, 23'd0, fbvs_pkg::SCALE_ONE);
		write_reg(REG_UNUSED, 23'h7F_FFFF);
		// Long receiver hold-off while the sender keeps offering items.
		@(posedge clk);
		hold_cycles = 300;
		@(negedge clk);
		no_idle = 1'b1;
		for (int i = 0; i < 80; i++) begin
			random_vertex();
		end
		no_idle = 1'b0;
		random_phase(100);

		set_scales(23'($urandom_range(0, 4194304)), 23'($urandom_range(0, 4194304)),
			23'($urandom_range(0, 4194304)));
		random_phase(125);

		set_scales(23'd0, 23'd4194304, 23'h3F_FFFF);
		random_phase(125);

		drain();
		if (sb.expected_pos.size() != 0 || sb.errors != 0) begin
			$display("tb: failure");
		end else begin
			$display("tb: success");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
